@@ src/lobm_pkg.sv @@
// Package for the limit order book matcher: field widths, action and status
// codes, and the record carried by each book cell. No dependencies.
package lobm_pkg;

  localparam int unsigned MaxOrdersDefault = 64;

  localparam int unsigned IdW    = 32;
  localparam int unsigned PriceW = 16;
  localparam int unsigned QtyW   = 16;
  localparam int unsigned TimeW  = 32;

  localparam logic [1:0] ActPlace  = 2'd0;
  localparam logic [1:0] ActCancel = 2'd1;
  localparam logic [1:0] ActMatch  = 2'd2;

  localparam logic [2:0] StPlaced    = 3'd0;
  localparam logic [2:0] StFull      = 3'd1;
  localparam logic [2:0] StCancelled = 3'd2;
  localparam logic [2:0] StMiss      = 3'd3;
  localparam logic [2:0] StTrade     = 3'd4;

  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  // One resting order as seen by the cells.
  typedef struct packed {
    logic              side;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   remaining;
    logic [IdW-1:0]    ident;
    logic [TimeW-1:0]  arrival;
  } order_t;

  // Best-candidate record that travels down the chain.
  typedef struct packed {
    logic        found;
    order_t      ord;
  } cand_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic            scan;     // a comparison pass is running
    logic [1:0]      mode;     // which pass: place, cancel, bid or ask
    logic [IdW-1:0]  key_id;
  } scan_cmd_t;

  localparam logic [1:0] ScanFree   = 2'd0;
  localparam logic [1:0] ScanCancel = 2'd1;
  localparam logic [1:0] ScanBid    = 2'd2;
  localparam logic [1:0] ScanAsk    = 2'd3;

  // True when candidate a ranks strictly before the current best b for a pass.
  function automatic logic better(input logic [1:0] mode, input order_t a,
                                  input order_t b);
    logic r;
    r = 1'b0;
    case (mode)
      ScanCancel: begin
        if (a.side != b.side) r = (a.side < b.side);
        else if (a.price != b.price) r = (a.price < b.price);
        else r = (a.arrival < b.arrival);
      end
      ScanBid: begin
        if (a.price != b.price) r = (a.price > b.price);
        else r = (a.arrival < b.arrival);
      end
      ScanAsk: begin
        if (a.price != b.price) r = (a.price < b.price);
        else r = (a.arrival < b.arrival);
      end
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ src/lobm_cell.sv @@
// One slot of the book: holds an order and takes part in the systolic search.
// Depends on lobm_pkg.
module lobm_cell #(
  parameter int unsigned IdxW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IdxW-1:0]      my_idx,
  input  lobm_pkg::scan_cmd_t  cmd,
  input  lobm_pkg::cand_t      cand_in,
  input  logic [IdxW-1:0]      cidx_in,
  output lobm_pkg::cand_t      cand_out_r,
  output logic [IdxW-1:0]      cidx_out_r,
  input  logic                 wr_en,
  input  logic                 wr_valid,
  input  lobm_pkg::order_t     wr_ord,
  input  logic                 qty_en,
  input  logic [lobm_pkg::QtyW-1:0] qty_new,
  output logic                 valid_o
);

  logic             valid_r;
  lobm_pkg::order_t ord_r;
  logic             elig;
  logic             take;

  assign valid_o = valid_r;

  always_comb begin
    elig = 1'b0;
    case (cmd.mode)
      lobm_pkg::ScanFree:   elig = !valid_r;
      lobm_pkg::ScanCancel: elig = valid_r && (ord_r.ident == cmd.key_id);
      lobm_pkg::ScanBid:    elig = valid_r && (ord_r.side == lobm_pkg::SideBuy);
      default:              elig = valid_r && (ord_r.side == lobm_pkg::SideSell);
    endcase
    // Earlier slots win ties, so a later cell replaces only on strict order.
    take = elig && (!cand_in.found || lobm_pkg::better(cmd.mode, ord_r, cand_in.ord)
                   && (cmd.mode != lobm_pkg::ScanFree));
  end

  always_ff @(posedge clk) begin
    cand_out_r.ord <= take ? ord_r : cand_in.ord;
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_out_r.found <= 1'b0;
    end else begin
      if (wr_en) valid_r <= wr_valid;
      if (take) begin
        cand_out_r.found <= 1'b1;
      end else begin
        cand_out_r.found <= cand_in.found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_valid) ord_r <= wr_ord;
    else if (qty_en) ord_r.remaining <= qty_new;
    cidx_out_r     <= take ? my_idx : cidx_in;
  end

endmodule

@@ src/lobm_ctrl.sv @@
// Sequencer of the order book: runs the search passes over the cell chain
// and forms the result. Depends on lobm_pkg.
module lobm_ctrl #(
  parameter int unsigned MaxOrders = lobm_pkg::MaxOrdersDefault,
  parameter int unsigned IdxW      = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [1:0]           act,
  input  lobm_pkg::order_t     in_ord,
  output logic                 busy,
  output lobm_pkg::scan_cmd_t  cmd,
  input  lobm_pkg::cand_t      res,
  input  logic [IdxW-1:0]      res_idx,
  output logic [MaxOrders-1:0] wr_en,
  output logic                 wr_valid,
  output lobm_pkg::order_t     wr_ord,
  output logic [MaxOrders-1:0] qty_en,
  output logic [lobm_pkg::QtyW-1:0] qty_new,
  output logic                 done,
  output logic [2:0]           st,
  output logic [lobm_pkg::IdW-1:0]   bid_id,
  output logic [lobm_pkg::IdW-1:0]   ask_id,
  output logic [lobm_pkg::QtyW-1:0]  tq,
  output logic [lobm_pkg::PriceW-1:0] tp,
  input  logic                 out_free
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_BID  = 5'b00100,
    S_RES  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam int unsigned CntW = $clog2(MaxOrders + 2);

  state_t              state_r, state_nxt;
  logic [CntW-1:0]     cnt_r;
  logic [1:0]          act_r;
  lobm_pkg::order_t    ord_r;
  lobm_pkg::cand_t     bid_r;
  logic [IdxW-1:0]     bidx_r;
  logic [1:0]          mode_r;
  logic [2:0]          st_r;
  logic [lobm_pkg::IdW-1:0]    bo_r, ao_r;
  logic [lobm_pkg::QtyW-1:0]   tq_r;
  logic [lobm_pkg::PriceW-1:0] tp_r;
  logic                 scan_end;
  logic [lobm_pkg::QtyW-1:0] q;

  assign busy     = (state_r != S_IDLE);
  assign cmd.scan = (state_r == S_SCAN) || (state_r == S_BID);
  assign cmd.mode = mode_r;
  assign cmd.key_id = ord_r.ident;
  assign scan_end = (cnt_r == CntW'(MaxOrders));
  assign wr_ord   = ord_r;
  assign done     = (state_r == S_OUT);
  assign st = st_r; assign bid_id = bo_r; assign ask_id = ao_r;
  assign tq = tq_r; assign tp = tp_r;
  assign q = (bid_r.ord.remaining < res.ord.remaining) ? bid_r.ord.remaining
                                                     : res.ord.remaining;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = (act == lobm_pkg::ActPlace ||
                                        act == lobm_pkg::ActCancel ||
                                        act == lobm_pkg::ActMatch) ? S_SCAN : S_RES;
      S_SCAN: if (scan_end) state_nxt = (act_r == lobm_pkg::ActMatch) ? S_BID : S_RES;
      S_BID:  if (scan_end) state_nxt = S_RES;
      S_RES:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell writes happen in the result step, from the index the chain returned.
  // A trade fills at least one side; only the other side can keep a remainder.
  always_comb begin
    wr_en    = '0;
    qty_en   = '0;
    wr_valid = 1'b0;
    qty_new  = '0;
    if (state_r == S_RES) begin
      case (act_r)
        lobm_pkg::ActPlace: if (res.found && ord_r.remaining != '0) begin
          wr_en[res_idx] = 1'b1; wr_valid = 1'b1;
        end
        lobm_pkg::ActCancel: if (res.found) wr_en[res_idx] = 1'b1;
        lobm_pkg::ActMatch: if (res.found && bid_r.found &&
                                bid_r.ord.price >= res.ord.price) begin
          if (bid_r.ord.remaining == q) begin
            wr_en[bidx_r] = 1'b1;
          end else begin
            qty_en[bidx_r] = 1'b1;
            qty_new = bid_r.ord.remaining - q;
          end
          if (res.ord.remaining == q) begin
            wr_en[res_idx] = 1'b1;
          end else begin
            qty_en[res_idx] = 1'b1;
            qty_new = res.ord.remaining - q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SCAN || state_r == S_BID) cnt_r <= scan_end ? '0 : cnt_r + 1'b1;
      else cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire) begin
      act_r <= act;
      ord_r <= in_ord;
      case (act)
        lobm_pkg::ActPlace:  mode_r <= lobm_pkg::ScanFree;
        lobm_pkg::ActCancel: mode_r <= lobm_pkg::ScanCancel;
        default:             mode_r <= lobm_pkg::ScanBid;
      endcase
    end
    if (state_r == S_SCAN && scan_end) begin
      bid_r  <= res;
      bidx_r <= res_idx;
      mode_r <= lobm_pkg::ScanAsk;
    end
    if (state_r == S_RES) begin
      st_r <= lobm_pkg::StMiss;
      bo_r <= '0; ao_r <= '0; tq_r <= '0; tp_r <= '0;
      case (act_r)
        lobm_pkg::ActPlace:  st_r <= res.found ? lobm_pkg::StPlaced : lobm_pkg::StFull;
        lobm_pkg::ActCancel: if (res.found) st_r <= lobm_pkg::StCancelled;
        lobm_pkg::ActMatch: if (res.found && bid_r.found &&
                                bid_r.ord.price >= res.ord.price) begin
          st_r <= lobm_pkg::StTrade;
          bo_r <= bid_r.ord.ident; ao_r <= res.ord.ident;
          tq_r <= q; tp_r <= res.ord.price;
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(wr_en & qty_en) == 0) else $error("write and trim same slot");
  a_write_res: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en != '0 || qty_en != '0) |-> state_r == S_RES) else $error("write out of step");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !out_free) |=> done) else $error("result dropped");
`endif

endmodule

@@ src/limit_order_book_matcher.sv @@
// Top level of the limit order book matcher: a chain of order cells and the
// sequencer that drives them. Depends on lobm_pkg, lobm_cell and lobm_ctrl.
//
// Channel | Direction | Fields (lowest bit first)
// in_     | slave     | tdata: action, order_id, side, price, quantity, arrival_time
// out_    | master    | tdata: status, buy_order_id, sell_order_id, trade_quantity,
//         |           |        trade_price
//
// Place and cancel run one search pass over the chain and match runs two, a bid pass
// and then an ask pass; an unused action skips the search. Each pass lets a
// candidate ripple through the whole cell chain, one cell per cycle. The next item
// can be taken in the cycle after the result transfer.
// Reset is synchronous and active low; it clears every slot's valid bit at once.
// A stalled result holds the block; the next item is taken once it transfers.
module limit_order_book_matcher #(
  parameter int unsigned MAX_ORDERS = lobm_pkg::MaxOrdersDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], order_id[33:2], side[34], price[50:35], quantity[66:51],
  // arrival_time[98:67], zero fill to 104 bits
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], buy_order_id[34:3], sell_order_id[66:35],
  // trade_quantity[82:67], trade_price[98:83], zero fill to 104 bits
  output logic [103:0] out_tdata
);

  localparam int unsigned IdxW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;

  lobm_pkg::scan_cmd_t        cmd;
  lobm_pkg::cand_t            chain [MAX_ORDERS+1];
  logic [IdxW-1:0]            cidx  [MAX_ORDERS+1];
  logic [MAX_ORDERS-1:0]      wr_en, qty_en, valid_v;
  logic                       wr_valid, busy, done;
  lobm_pkg::order_t           wr_ord, in_ord;
  logic [lobm_pkg::QtyW-1:0]  qty_new;
  logic [2:0]                 st;
  logic [lobm_pkg::IdW-1:0]   bo, ao;
  logic [lobm_pkg::QtyW-1:0]  tq;
  logic [lobm_pkg::PriceW-1:0] tp;
  logic                       in_fire;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign in_ord.ident     = in_tdata[33:2];
  assign in_ord.side      = in_tdata[34];
  assign in_ord.price     = in_tdata[50:35];
  assign in_ord.remaining = in_tdata[66:51];
  assign in_ord.arrival   = in_tdata[98:67];

  // The head of the chain starts each pass with no candidate.
  assign chain[0] = '0;
  assign cidx[0]  = '0;

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lobm_cell #(.IdxW(IdxW)) u_cell (
      .clk, .rst_n,
      .my_idx(IdxW'(g)), .cmd,
      .cand_in(chain[g]), .cidx_in(cidx[g]),
      .cand_out_r(chain[g+1]), .cidx_out_r(cidx[g+1]),
      .wr_en(wr_en[g]), .wr_valid, .wr_ord,
      .qty_en(qty_en[g]), .qty_new,
      .valid_o(valid_v[g])
    );
  end

  lobm_ctrl #(.MaxOrders(MAX_ORDERS), .IdxW(IdxW)) u_ctrl (
    .clk, .rst_n, .in_fire, .act(in_tdata[1:0]), .in_ord,
    .busy, .cmd, .res(chain[MAX_ORDERS]), .res_idx(cidx[MAX_ORDERS]),
    .wr_en, .wr_valid, .wr_ord, .qty_en, .qty_new,
    .done, .st, .bid_id(bo), .ask_id(ao), .tq, .tp, .out_free(out_tready)
  );

  assign out_tvalid = done;
  assign out_tdata  = {5'd0, tp, tq, ao, bo, st};

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st == lobm_pkg::StFull) |-> (&valid_v)) else $error("bad full");
  a_valid_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> valid_v == '0) else $error("valid not cleared");
`endif

endmodule

@@ tb/sv/limit_order_book_matcher_tb.sv @@
// Self-checking bench: directed and random order streams checked against an in-bench
// price-time priority book. Depends on lobm_pkg and limit_order_book_matcher.
`timescale 1ns / 1ps

module limit_order_book_matcher_tb;
  import lobm_pkg::*;

  localparam int unsigned Slots = 64;
  localparam int unsigned CycleLimit = 1500000;
  localparam logic [1:0] ActSpare = 2'd3;  // unused action code, answered as a miss

  // One request to the book.
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] order_id;
    logic        side;
    logic [15:0] price;
    logic [15:0] quantity;
    logic [31:0] arrival;
  } request_t;

  // One answer from the book.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [15:0] qty;
    logic [15:0] price;
  } answer_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;

  limit_order_book_matcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Shadow copy of the book.
  logic        bk_valid [Slots];
  logic        bk_side  [Slots];
  logic [15:0] bk_price [Slots];
  logic [15:0] bk_left  [Slots];
  logic [31:0] bk_id    [Slots];
  logic [31:0] bk_time  [Slots];

  answer_t pending_answers[$];
  int      failures;
  int      cycles;
  int      hold_off;       // cycles the receiver must still stall
  bit      sender_bursty;  // the sender inserts random gaps
  int      live_ids[$];    // ids recently placed, reused for cancels

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Best resting order on one side by price, then arrival, then slot; -1 if none.
  function automatic int best_on_side(logic want);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!bk_valid[i] || bk_side[i] != want) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (bk_price[i] == bk_price[best]) better = bk_time[i] < bk_time[best];
      else if (want == SideBuy) better = bk_price[i] > bk_price[best];
      else better = bk_price[i] < bk_price[best];
      if (better) best = i;
    end
    return best;
  endfunction

  // Entry that a cancel removes: buy first, then lower price, earlier time, slot.
  function automatic int cancel_target(logic [31:0] id);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!bk_valid[i] || bk_id[i] != id) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (bk_side[i] != bk_side[best]) better = bk_side[i] < bk_side[best];
      else if (bk_price[i] != bk_price[best]) better = bk_price[i] < bk_price[best];
      else better = bk_time[i] < bk_time[best];
      if (better) best = i;
    end
    return best;
  endfunction

  // Applies one request to the shadow book and returns the answer it yields.
  function automatic answer_t apply_to_book(request_t r);
    answer_t a;
    int slot;
    int b;
    int s;
    logic [15:0] q;
    a = '{StMiss, 32'd0, 32'd0, 16'd0, 16'd0};
    if (r.action == ActPlace) begin
      slot = -1;
      for (int i = 0; i < Slots; i++)
        if (slot < 0 && !bk_valid[i]) slot = i;
      if (slot < 0) begin
        a.status = StFull;
      end else begin
        a.status = StPlaced;
        if (r.quantity != 0) begin
          bk_valid[slot] = 1'b1;
          bk_side[slot]  = r.side;
          bk_price[slot] = r.price;
          bk_left[slot]  = r.quantity;
          bk_id[slot]    = r.order_id;
          bk_time[slot]  = r.arrival;
        end
      end
    end else if (r.action == ActCancel) begin
      slot = cancel_target(r.order_id);
      if (slot >= 0) begin
        bk_valid[slot] = 1'b0;
        a.status = StCancelled;
      end
    end else if (r.action == ActMatch) begin
      b = best_on_side(SideBuy);
      s = best_on_side(SideSell);
      if (b >= 0 && s >= 0 && bk_price[b] >= bk_price[s]) begin
        q = (bk_left[b] < bk_left[s]) ? bk_left[b] : bk_left[s];
        a = '{StTrade, bk_id[b], bk_id[s], q, bk_price[s]};
        bk_left[b] -= q;
        bk_left[s] -= q;
        if (bk_left[b] == 0) bk_valid[b] = 1'b0;
        if (bk_left[s] == 0) bk_valid[s] = 1'b0;
      end
    end
    return a;
  endfunction

  function automatic int resting_count();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) n += bk_valid[i];
    return n;
  endfunction

  // Offers one request and holds it until the transfer happens; the expected
  // answer is queued at that edge. In bursty mode a random gap may precede it.
  // Valid stays high after a transfer so that the next request follows at once.
  task automatic send_request(request_t r);
    if (sender_bursty && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, r.arrival, r.quantity, r.price, r.side, r.order_id, r.action};
    do @(posedge clk); while (!in_tready);
    pending_answers.insert(pending_answers.size(), apply_to_book(r));
  endtask

  task automatic send_order(logic [1:0] act, logic [31:0] id, logic sd,
                            logic [15:0] pr, logic [15:0] qt, logic [31:0] tm);
    request_t r;
    r = '{act, id, sd, pr, qt, tm};
    if (act == ActPlace && qt != 0) live_ids.insert(live_ids.size(), id);
    if (live_ids.size() > 40) void'(live_ids.pop_front());
    send_request(r);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Checks each result transfer against the oldest expected answer.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[2:0], out_tdata[34:3], out_tdata[66:35], out_tdata[82:67],
              out_tdata[98:83]};
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, got.status);
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d buy=%h sell=%h q=%0d p=%0d",
                   $time, want.status, want.buy_id, want.sell_id, want.qty, want.price);
          $display("%0t:          actual   st=%0d buy=%h sell=%h q=%0d p=%0d",
                   $time, got.status, got.buy_id, got.sell_id, got.qty, got.price);
          failures++;
        end
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise a stall pattern of its own.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (cycles % 3000 < 1000) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("limit_order_book_matcher_tb: FAIL");
      $finish;
    end
  end

  // Book full, zero quantity, duplicate ids and every action at its extremes.
  task automatic test_directed();
    send_order(ActMatch, 32'd0, 1'b0, 16'd0, 16'd0, 32'd0);     // empty book
    send_order(ActCancel, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0, 32'd0);
    send_order(ActPlace, 32'd7, SideBuy, 16'd0, 16'd0, 32'd0);  // zero quantity
    send_order(ActPlace, 32'hFFFF_FFFF, SideBuy, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_order(ActPlace, 32'd1, SideSell, 16'd0, 16'd1, 32'd0);
    send_order(ActMatch, 32'd0, 1'b0, 16'd0, 16'd0, 32'd0);     // trade at zero
    send_order(ActPlace, 32'd5, SideSell, 16'd9, 16'd10, 32'd3);
    send_order(ActPlace, 32'd5, SideBuy, 16'd9, 16'd10, 32'd3); // duplicate id
    send_order(ActPlace, 32'd5, SideBuy, 16'd4, 16'd10, 32'd2);
    send_order(ActCancel, 32'd5, 1'b0, 16'd0, 16'd0, 32'd0);    // lower buy goes
    send_order(ActCancel, 32'd5, 1'b0, 16'd0, 16'd0, 32'd0);
    send_order(ActMatch, 32'd0, 1'b0, 16'd0, 16'd0, 32'd0);
    send_order(ActSpare, 32'hA5A5_A5A5, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_order(ActPlace, 32'd8, SideSell, 16'd20, 16'd3, 32'd1);
    send_order(ActPlace, 32'd9, SideBuy, 16'd19, 16'd3, 32'd1);
    send_order(ActMatch, 32'd0, 1'b0, 16'd0, 16'd0, 32'd0);     // the resting top buy still crosses
    // Fill the book, then overflow it once.
    while (resting_count() < Slots)
      send_order(ActPlace, $urandom, 1'($urandom_range(0, 1)), 16'($urandom), 16'd1,
                 $urandom);
    send_order(ActPlace, 32'd77, SideBuy, 16'd1, 16'd1, 32'd1);
    wait_drained();
  endtask

  // Work the full book down with matches and cancels, stopping once it is empty.
  task automatic test_drain();
    for (int i = 0; i < 80; i++) begin
      if (resting_count() == 0) break;
      if (i % 2) send_order(ActMatch, 32'd0, 1'b0, 16'd0, 16'd0, 32'd0);
      else send_order(ActCancel, live_ids[$urandom_range(0, live_ids.size() - 1)],
                      1'b0, 16'd0, 16'd0, 32'd0);
    end
    wait_drained();
  endtask

  // Random order flow around a narrow price band so that trades happen often.
  task automatic test_random(int count, int base_price);
    int pick;
    logic [15:0] pr;
    logic [15:0] qt;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      pr = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                        : 16'(base_price + $urandom_range(0, 15));
      qt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      if (pick < 50)
        send_order(ActPlace, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom,
                   1'($urandom_range(0, 1)), pr, qt,
                   $urandom_range(0, 31) << $urandom_range(0, 27));
      else if (pick < 65 && live_ids.size() != 0)
        send_order(ActCancel, live_ids[$urandom_range(0, live_ids.size() - 1)], 1'b0,
                   16'd0, 16'd0, 32'd0);
      else if (pick < 70)
        send_order(ActCancel, $urandom, 1'b0, 16'd0, 16'd0, 32'd0);
      else if (pick < 98)
        send_order(ActMatch, $urandom, 1'($urandom_range(0, 1)), 16'($urandom),
                   16'($urandom), $urandom);
      else
        send_order(ActSpare, $urandom, 1'($urandom_range(0, 1)), 16'($urandom),
                   16'($urandom), $urandom);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_off = 2000;
    test_random(20, 1000);
    wait_drained();
  endtask

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    failures   = 0;
    cycles     = 0;
    hold_off   = 0;
    sender_bursty = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      bk_valid[i] = 1'b0;
      bk_side[i]  = 1'b0;
      bk_price[i] = '0;
      bk_left[i]  = '0;
      bk_id[i]    = '0;
      bk_time[i]  = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_drain();
    sender_bursty = 1'b1;
    test_random(600, 100);
    // The sender pauses here until every answer is in.
    wait_drained();
    test_backpressure();
    sender_bursty = 1'b0;
    test_random(300, 60000);
    sender_bursty = 1'b1;
    test_random(400, 0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (failures == 0) begin
      $display("limit_order_book_matcher_tb: PASS");
    end else begin
      $display("limit_order_book_matcher_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lobm_pkg.sv
src/lobm_cell.sv
src/lobm_ctrl.sv
src/limit_order_book_matcher.sv
tb/sv/limit_order_book_matcher_tb.sv
